// File: rtl/core/lfu_cache_table_assert.svh
// Assertion macros for the LFU cache table.
// Depends on nothing; included by the checker module.
`ifndef LFU_CACHE_TABLE_ASSERT_SVH
`define LFU_CACHE_TABLE_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define LCT_ASSERT_RST(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("lfu_cache_table assertion failed");

// Clocked assertion that also holds through reset.
`define LCT_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("lfu_cache_table assertion failed");

`endif

// File: rtl/core/lct_pkg.sv
// Shared types and constants for the LFU cache table.
// No dependencies; imported by every module of the block.
package lct_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned RANK_W   = 4;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] lookup_key;
    logic [VAL_W-1:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic             hit;
    logic [VAL_W-1:0] read_value;
  } out_item_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic commit;
  } dp_cmd_t;

endpackage

// File: rtl/core/lct_ctrl.sv
// Controller for the LFU cache table: capture, evaluate, write-back.
// Depends on lct_pkg; drives the datapath command struct.
module lct_ctrl
  import lct_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_WRITE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        // hold until the result register is free
        if (!out_valid_r || out_ready) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// File: rtl/core/lct_datapath.sv
// Datapath for the LFU cache table: entry table, key match, victim search,
// write-back and result register. Depends on lct_pkg.
module lct_datapath
  import lct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  in_item_t         in_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data,
  output out_item_t        out_data
);

  logic [ENTRIES-1:0] valid_r;
  logic [KEY_W-1:0]   key_r   [ENTRIES];
  logic [VAL_W-1:0]   value_r [ENTRIES];
  logic [CNT_W-1:0]   count_r [ENTRIES];
  logic [RANK_W-1:0]  rank_r  [ENTRIES];

  logic [CAP_W-1:0]   cap_r;
  in_item_t           item_r;
  out_item_t          out_r;

  // evaluation results
  logic               hit_r;
  logic [IDX_W-1:0]   match_r, victim_r, free_r;
  logic               full_r, cap_zero_r;

  logic               hit_c;
  logic [IDX_W-1:0]   match_c, free_c;
  logic [CAP_W-1:0]   vcount_c, cap_c;

  localparam int unsigned SK_W = 1 + CNT_W + RANK_W;
  logic [SK_W-1:0]    l0_k [16];
  logic [IDX_W-1:0]   l0_i [16];
  logic [SK_W-1:0]    l1_k [8];
  logic [IDX_W-1:0]   l1_i [8];
  logic [SK_W-1:0]    l2_k [4];
  logic [IDX_W-1:0]   l2_i [4];
  logic [SK_W-1:0]    l3_k [2];
  logic [IDX_W-1:0]   l3_i [2];
  logic [IDX_W-1:0]   victim_c;

  assign out_data = out_r;

  always_comb begin
    hit_c   = 1'b0;
    match_c = '0;
    free_c  = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && key_r[i] == item_r.lookup_key) begin
        hit_c   = 1'b1;
        match_c = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_c = IDX_W'(i);
      end
    end
    vcount_c = CAP_W'($countones(valid_r));
    cap_c    = (cap_r > CAP_W'(ENTRIES)) ? CAP_W'(ENTRIES) : cap_r;
  end

  // Victim: smallest count, then largest rank; invalid entries sort last.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      l0_k[i] = {~valid_r[i], count_r[i], ~rank_r[i]};
      l0_i[i] = IDX_W'(i);
    end
    for (int i = 0; i < 8; i++) begin
      if (l0_k[2*i+1] < l0_k[2*i]) begin
        l1_k[i] = l0_k[2*i+1]; l1_i[i] = l0_i[2*i+1];
      end else begin
        l1_k[i] = l0_k[2*i];   l1_i[i] = l0_i[2*i];
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (l1_k[2*i+1] < l1_k[2*i]) begin
        l2_k[i] = l1_k[2*i+1]; l2_i[i] = l1_i[2*i+1];
      end else begin
        l2_k[i] = l1_k[2*i];   l2_i[i] = l1_i[2*i];
      end
    end
    for (int i = 0; i < 2; i++) begin
      if (l2_k[2*i+1] < l2_k[2*i]) begin
        l3_k[i] = l2_k[2*i+1]; l3_i[i] = l2_i[2*i+1];
      end else begin
        l3_k[i] = l2_k[2*i];   l3_i[i] = l2_i[2*i];
      end
    end
    victim_c = (l3_k[1] < l3_k[0]) ? l3_i[1] : l3_i[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_data;
    end
    if (cmd.eval) begin
      hit_r      <= hit_c;
      match_r    <= match_c;
      free_r     <= free_c;
      victim_r   <= victim_c;
      full_r     <= (vcount_c >= cap_c);
      cap_zero_r <= (cap_c == '0);
    end
  end

  logic             is_put;
  logic [IDX_W-1:0] slot;
  assign is_put = (item_r.command == CMD_PUT);
  assign slot   = full_r ? victim_r : free_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit) begin
      if (hit_r && (!is_put || !cap_zero_r)) begin
        // touch: younger entries age by one, hit becomes most recent
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && IDX_W'(i) != match_r && rank_r[i] < rank_r[match_r]) begin
            rank_r[i] <= rank_r[i] + RANK_W'(1);
          end
        end
        rank_r[match_r] <= '0;
        if (count_r[match_r] != CNT_MAX) begin
          count_r[match_r] <= count_r[match_r] + CNT_W'(1);
        end
        if (is_put) begin
          value_r[match_r] <= item_r.write_value;
        end
      end else if (!hit_r && is_put && !cap_zero_r) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (valid_r[i] && IDX_W'(i) != slot) begin
            if (full_r && rank_r[i] > rank_r[victim_r]) begin
              rank_r[i] <= rank_r[i];
            end else begin
              rank_r[i] <= rank_r[i] + RANK_W'(1);
            end
          end
        end
        valid_r[slot] <= 1'b1;
        key_r[slot]   <= item_r.lookup_key;
        value_r[slot] <= item_r.write_value;
        count_r[slot] <= CNT_W'(1);
        rank_r[slot]  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r.hit        <= hit_r;
      out_r.read_value <= (hit_r && !is_put) ? value_r[match_r] : '0;
    end
  end

endmodule

// File: rtl/core/lfu_cache_table.sv
// LFU cache table: 16-entry key-value store with least-frequently-used
// replacement and least-recently-used tie break. One access is in flight at a
// time. The input transfer captures the item, the evaluate state registers the
// parallel key match and min-count victim search over the register table, and
// the write state writes back the entry table and the result register once
// the result register is free. A new item is taken in the cycle after
// write-back; a stalled result holds write-back of the next.
// Depends on lct_pkg, lct_ctrl and lct_datapath.
module lfu_cache_table
  import lct_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_wr_en,
  input  logic [CAP_W-1:0] cfg_wr_data
);

  dp_cmd_t cmd;

  lct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  lct_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_data    (out_data)
  );

endmodule

// File: rtl/core/lct_checker.sv
// Port-level checks for the LFU cache table, bound to the top level.
// Depends on lct_pkg and lfu_cache_table_assert.svh.
`include "lfu_cache_table_assert.svh"

module lct_checker
  import lct_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  `LCT_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `LCT_ASSERT_RST(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready)
  `LCT_ASSERT_RST(a_no_early_result, clk, rst_n, in_valid && in_ready && !out_valid |=> !out_valid)
  `LCT_ASSERT_RST(a_miss_reads_zero, clk, rst_n, out_valid && !out_data.hit |-> out_data.read_value == '0)
  `LCT_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)

endmodule

bind lfu_cache_table lct_checker u_lct_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/tb_lfu_cache_table.sv
// Self-checking testbench for lfu_cache_table: random gets and puts with random idling on
// both channels, checked against a predictor of the LFU table kept in a scoreboard class.
// Depends on lct_pkg and the lfu_cache_table RTL.
module tb_lfu_cache_table;
  timeunit 1ns;
  timeprecision 1ps;
  import lct_pkg::*;

  class lfu_scoreboard;
    logic [CAP_W-1:0]  capacity;
    logic              slot_used [ENTRIES];
    logic [KEY_W-1:0]  slot_key  [ENTRIES];
    logic [VAL_W-1:0]  slot_val  [ENTRIES];
    logic [CNT_W-1:0]  slot_cnt  [ENTRIES];
    logic [RANK_W-1:0] slot_rank [ENTRIES];
    out_item_t         pending_q [$];
    int                mismatches;
    int                checked;
    int                hits;
    int                evictions;

    function new();
      capacity = CAP_RESET;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      mismatches = 0;
      checked = 0;
      hits = 0;
      evictions = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    // Count one use and move the slot to the front of the recency order.
    function void bump(int s);
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
      slot_rank[s] = '0;
      if (slot_cnt[s] != CNT_MAX) slot_cnt[s]++;
    endfunction

    // Drop the lowest-count entry, oldest first among equal counts.
    function int drop_victim();
      int v;
      v = -1;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!slot_used[i]) continue;
        if (v < 0 || slot_cnt[i] < slot_cnt[v] ||
            (slot_cnt[i] == slot_cnt[v] && slot_rank[i] > slot_rank[v])) v = i;
      end
      if (v < 0) return -1;
      for (int i = 0; i < ENTRIES; i++)
        if (slot_used[i] && i != v && slot_rank[i] > slot_rank[v]) slot_rank[i]--;
      slot_used[v] = 1'b0;
      evictions++;
      return v;
    endfunction

    function void note_item(in_item_t it);
      int        s;
      int        slot;
      int        stored;
      int        cap_eff;
      out_item_t res;
      s = -1;
      stored = 0;
      cap_eff = (capacity > ENTRIES) ? ENTRIES : capacity;
      for (int i = ENTRIES - 1; i >= 0; i--)
        if (slot_used[i] && slot_key[i] == it.lookup_key) s = i;
      foreach (slot_used[i]) if (slot_used[i]) stored++;
      res.hit = (s >= 0);
      res.read_value = '0;
      if (it.command == CMD_GET) begin
        if (s >= 0) begin
          bump(s);
          res.read_value = slot_val[s];
        end
      end else if (cap_eff != 0) begin
        if (s >= 0) begin
          slot_val[s] = it.write_value;
          bump(s);
        end else begin
          slot = -1;
          if (stored >= cap_eff) begin
            slot = drop_victim();
          end else begin
            for (int i = ENTRIES - 1; i >= 0; i--) if (!slot_used[i]) slot = i;
          end
          if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) if (slot_used[i]) slot_rank[i]++;
            slot_used[slot] = 1'b1;
            slot_key[slot]  = it.lookup_key;
            slot_val[slot]  = it.write_value;
            slot_cnt[slot]  = 1;
            slot_rank[slot] = '0;
          end
        end
      end
      if (res.hit) hits++;
      pending_q.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result with nothing pending: hit=%0b value=%h",
                                       got.hit, got.read_value);
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (got.hit !== exp_r.hit || got.read_value !== exp_r.read_value) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected hit=%0b value=%h, got hit=%0b value=%h",
                   checked, exp_r.hit, exp_r.read_value, got.hit, got.read_value);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;
  logic             cfg_wr_en;
  logic [CAP_W-1:0] cfg_wr_data;

  lfu_scoreboard sb;
  bit            steady;      // when set, neither side idles
  int            sent;
  int            stall_cycles;

  localparam int STALL_LIMIT = 5000;

  lfu_cache_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int draw_gap();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic send_item(logic cmd, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    int gap;
    gap = draw_gap();
    repeat (gap) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data.command = cmd;
    in_data.lookup_key = k;
    in_data.write_value = v;
    do @(posedge clk); while (!in_ready);
    sb.note_item(in_data);
    sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] c);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = c;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_capacity(c);
  endtask

  // Keys mostly from a small pool so gets hit and counts build up.
  task automatic random_items(int n, int pool);
    logic [KEY_W-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) k = $urandom();
      else k = $urandom_range(0, pool - 1);
      if (i % 100 == 50) steady = ~steady;
      send_item(1'($urandom_range(0, 1)), k, $urandom());
    end
  endtask

  // Result side: random stall per transfer, check at the accepting edge.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = draw_gap();
      repeat (stall) begin
        out_ready = 1'b0;
        @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_data);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("tb_lfu_cache_table: done, errors");
      $finish;
    end
  end

  initial begin
    sb = new();
    steady = 1'b0;
    sent = 0;
    stall_cycles = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed: extremes, update, fill to capacity, then LFU and LRU tie evictions.
    write_capacity(5'd16);
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_PUT, 32'h0, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 32'hFFFF_FFFF, 32'h0);
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(CMD_PUT, 32'h0, 32'h5A5A_A5A5);
    send_item(CMD_GET, 32'h0, 32'h0);
    for (int i = 1; i <= 15; i++) send_item(CMD_PUT, 32'h100 + i, i);
    send_item(CMD_PUT, 32'hDEAD_BEEF, 32'h1234_5678);
    send_item(CMD_GET, 32'h101, 32'h0);

    // Zero capacity: puts are ignored, gets still work.
    write_capacity(5'd0);
    send_item(CMD_PUT, 32'h0, 32'h1);
    send_item(CMD_PUT, 32'h7777, 32'h2);
    send_item(CMD_GET, 32'h0, 32'h0);
    send_item(CMD_GET, 32'h7777, 32'h0);
    random_items(60, 24);

    // Above the table size acts as full size; then lower below the stored count.
    write_capacity(5'd31);
    random_items(200, 24);
    write_capacity(5'd3);
    random_items(100, 8);
    write_capacity(5'd1);
    random_items(80, 4);
    write_capacity(5'd4);
    random_items(150, 10);
    write_capacity(5'd16);
    random_items(210, 24);

    drain();
    repeat (10) @(posedge clk);
    if (sb.pending_q.size() != 0) sb.mismatches += sb.pending_q.size();
    $display("Ran %0d gets/puts across capacities 0, 1, 3, 4, 16 and 31: %0d results checked,",
             sent, sb.checked);
    $display("%0d hits, %0d evictions, %0d mismatches.", sb.hits, sb.evictions, sb.mismatches);
    if (sb.mismatches == 0)
      $display("tb_lfu_cache_table: done, clean");
    else
      $display("tb_lfu_cache_table: done, errors");
    $finish;
  end
endmodule
